/* rtl/srl_pkg.sv */
// Shared types and constants for the script region lexer.
// Holds the classified-byte and result records and the keyword character tables.
// No dependencies.
package srl_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int MODE_W = 4;
   localparam int KIND_W = 2;
   localparam int LEN_W  = 4;

   // Method name tracking
   localparam logic [LEN_W-1:0] LISTEN_LEN   = 4'd6;
   localparam logic [LEN_W-1:0] DELEGATE_LEN = 4'd8;
   localparam logic [LEN_W-1:0] NAME_SAT     = 4'd9;

   // Call kind codes reported at an open parenthesis
   localparam logic [KIND_W-1:0] CALL_NONE     = 2'd0;
   localparam logic [KIND_W-1:0] CALL_LISTEN   = 2'd1;
   localparam logic [KIND_W-1:0] CALL_DELEGATE = 2'd2;
   localparam logic [KIND_W-1:0] CALL_OTHER    = 2'd3;

   // Character codes
   localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [BYTE_W-1:0] CH_BACKTICK  = 8'h60;
   localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_GT        = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
   localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'h24;

   // One byte with its character classes, decoded by the front end
   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              is_dquote;
      logic              is_squote;
      logic              is_backtick;
      logic              is_backslash;
      logic              is_slash;
      logic              is_star;
      logic              is_lbrace;
      logic              is_rbrace;
      logic              is_minus;
      logic              is_gt;
      logic              is_newline;
      logic              is_space;
      logic              is_ident_start;
      logic              is_ident_part;
      logic              is_lparen;
   } class_type;

   // One result
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              selector_byte;
      logic              selector_closed;
      logic              method_byte;
      logic [KIND_W-1:0] call_kind;
   } result_type;

   // Characters of "listen" by position
   function automatic logic [BYTE_W-1:0] listen_char(input logic [LEN_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h6C; // l
         4'd1:    ch = 8'h69; // i
         4'd2:    ch = 8'h73; // s
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Characters of "delegate" by position
   function automatic logic [BYTE_W-1:0] delegate_char(input logic [LEN_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      unique case (idx)
         4'd0:    ch = 8'h64; // d
         4'd1:    ch = 8'h65; // e
         4'd2:    ch = 8'h6C; // l
         4'd3:    ch = 8'h65; // e
         4'd4:    ch = 8'h67; // g
         4'd5:    ch = 8'h61; // a
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h65; // e
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/srl_front.sv */
// Front end of the script region lexer: accepts request bytes and decodes character classes.
// Depends on srl_pkg.
module srl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  logic                  queue_full,
   output logic                  push,
   output srl_pkg::class_type    push_item
);

   logic               valid_ff;
   logic               valid_in;
   srl_pkg::class_type item_ff;
   srl_pkg::class_type item_in;
   logic               take;
   logic               is_lower;
   logic               is_upper;
   logic               is_digit;

   // Hand the held byte to the queue whenever it has room
   assign push      = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign push_item = item_ff;
   assign take      = req_valid && !req_stall;

   // Character class decode
   assign is_lower = (req_text_byte >= 8'h61) && (req_text_byte <= 8'h7A);
   assign is_upper = (req_text_byte >= 8'h41) && (req_text_byte <= 8'h5A);
   assign is_digit = (req_text_byte >= 8'h30) && (req_text_byte <= 8'h39);

   always_comb begin
      item_in.text_byte      = req_text_byte;
      item_in.is_dquote      = (req_text_byte == srl_pkg::CH_DQUOTE);
      item_in.is_squote      = (req_text_byte == srl_pkg::CH_SQUOTE);
      item_in.is_backtick    = (req_text_byte == srl_pkg::CH_BACKTICK);
      item_in.is_backslash   = (req_text_byte == srl_pkg::CH_BACKSLASH);
      item_in.is_slash       = (req_text_byte == srl_pkg::CH_SLASH);
      item_in.is_star        = (req_text_byte == srl_pkg::CH_STAR);
      item_in.is_lbrace      = (req_text_byte == srl_pkg::CH_LBRACE);
      item_in.is_rbrace      = (req_text_byte == srl_pkg::CH_RBRACE);
      item_in.is_minus       = (req_text_byte == srl_pkg::CH_MINUS);
      item_in.is_gt          = (req_text_byte == srl_pkg::CH_GT);
      item_in.is_newline     = (req_text_byte == srl_pkg::CH_NEWLINE);
      item_in.is_space       = (req_text_byte == srl_pkg::CH_SPACE)
                            || (req_text_byte == srl_pkg::CH_TAB)
                            || (req_text_byte == srl_pkg::CH_NEWLINE)
                            || (req_text_byte == srl_pkg::CH_CR);
      item_in.is_ident_start = is_lower || is_upper
                            || (req_text_byte == srl_pkg::CH_UNDERSCORE)
                            || (req_text_byte == srl_pkg::CH_DOLLAR);
      item_in.is_ident_part  = item_in.is_ident_start || is_digit;
      item_in.is_lparen      = (req_text_byte == srl_pkg::CH_LPAREN);
   end

   // Holding register occupancy
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/srl_queue.sv */
// Two-entry queue of classified bytes between the lexer front and back ends.
// Depends on srl_pkg.
module srl_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  srl_pkg::class_type    push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output srl_pkg::class_type    pop_item
);

   srl_pkg::class_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/srl_back.sv */
// Back end of the script region lexer: lexical mode state machine and result register.
// Depends on srl_pkg.
module srl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  srl_pkg::class_type    item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srl_pkg::result_type   result
);

   typedef enum logic [3:0] {
      MODE_CODE     = 4'd0,
      MODE_STRING   = 4'd1,
      MODE_TEMPLATE = 4'd2,
      MODE_LINE     = 4'd3,
      MODE_BLOCK    = 4'd4,
      MODE_SEL      = 4'd5,
      MODE_SEL_END  = 4'd6,
      MODE_ARROW    = 4'd7,
      MODE_METHOD   = 4'd8,
      MODE_LISTEN   = 4'd9,
      MODE_DELEGATE = 4'd10,
      MODE_ERROR    = 4'd11
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic                      quote_dq_ff, quote_dq_in;
   logic                      str_esc_ff, str_esc_in;
   logic                      tpl_esc_ff, tpl_esc_in;
   logic                      pending_ff, pending_in;
   logic                      prev_slash_ff, prev_slash_in;
   logic                      prev_minus_ff, prev_minus_in;
   logic                      prev_star_ff, prev_star_in;
   logic [srl_pkg::LEN_W-1:0] name_len_ff, name_len_in;
   logic                      listen_ff, listen_in;
   logic                      delegate_ff, delegate_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   srl_pkg::result_type       result_ff, result_in;
   logic                      quote_close;

   // Take the next byte whenever the result register is free or being drained
   assign pop       = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   assign quote_close = (item.is_dquote && quote_dq_ff) || (item.is_squote && !quote_dq_ff);

   // Next-state and result decode for one byte
   always_comb begin
      mode_in       = mode_ff;
      quote_dq_in   = quote_dq_ff;
      str_esc_in    = str_esc_ff;
      tpl_esc_in    = tpl_esc_ff;
      pending_in    = pending_ff;
      prev_slash_in = prev_slash_ff;
      prev_minus_in = prev_minus_ff;
      prev_star_in  = prev_star_ff;
      name_len_in   = name_len_ff;
      listen_in     = listen_ff;
      delegate_in   = delegate_ff;
      result_in.selector_byte   = 1'b0;
      result_in.selector_closed = 1'b0;
      result_in.method_byte     = 1'b0;
      result_in.call_kind       = srl_pkg::CALL_NONE;

      unique case (mode_ff)
         MODE_CODE: begin
            if (item.is_dquote || item.is_squote) begin
               quote_dq_in = item.is_dquote;
               mode_in     = MODE_STRING;
            end else if (item.is_backtick) begin
               mode_in = MODE_TEMPLATE;
            end else if (prev_slash_ff && item.is_slash) begin
               mode_in = MODE_LINE;
            end else if (prev_slash_ff && item.is_star) begin
               mode_in = MODE_BLOCK;
            end else if (item.is_lbrace && pending_ff) begin
               // second open brace starts a selector; previous byte kept
               pending_in = 1'b0;
               mode_in    = MODE_SEL;
            end else begin
               pending_in = item.is_lbrace;
               if (prev_minus_ff && item.is_gt) begin
                  mode_in = MODE_ARROW;
               end else begin
                  prev_slash_in = item.is_slash;
                  prev_minus_in = item.is_minus;
               end
            end
         end
         MODE_STRING: begin
            if (str_esc_ff) begin
               str_esc_in = 1'b0;
            end else if (item.is_backslash) begin
               str_esc_in = 1'b1;
            end else if (quote_close) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_TEMPLATE: begin
            if (tpl_esc_ff) begin
               tpl_esc_in = 1'b0;
            end else if (item.is_backslash) begin
               tpl_esc_in = 1'b1;
            end else if (item.is_backtick) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_LINE: begin
            if (item.is_newline) begin
               mode_in = MODE_CODE;
            end
         end
         MODE_BLOCK: begin
            if (prev_star_ff && item.is_slash) begin
               mode_in = MODE_CODE;
            end
            prev_star_in = item.is_star;
         end
         MODE_SEL: begin
            if (item.is_rbrace) begin
               mode_in = MODE_SEL_END;
            end else begin
               result_in.selector_byte = 1'b1;
            end
         end
         MODE_SEL_END: begin
            if (item.is_rbrace) begin
               result_in.selector_closed = 1'b1;
               mode_in = MODE_CODE;
            end else begin
               mode_in = MODE_ERROR;
            end
         end
         MODE_ARROW: begin
            // whitespace is skipped
            if (!item.is_space) begin
               if (item.is_ident_start) begin
                  name_len_in = 4'd1;
                  listen_in   = (item.text_byte == srl_pkg::listen_char(4'd0));
                  delegate_in = (item.text_byte == srl_pkg::delegate_char(4'd0));
                  result_in.method_byte = 1'b1;
                  mode_in = MODE_METHOD;
               end else begin
                  mode_in = MODE_CODE;
               end
            end
         end
         MODE_METHOD, MODE_LISTEN, MODE_DELEGATE: begin
            if (item.is_ident_part) begin
               // keep only prefix matches and a saturating length
               listen_in   = listen_ff && (name_len_ff < srl_pkg::LISTEN_LEN)
                          && (srl_pkg::listen_char(name_len_ff) == item.text_byte);
               delegate_in = delegate_ff && (name_len_ff < srl_pkg::DELEGATE_LEN)
                          && (srl_pkg::delegate_char(name_len_ff) == item.text_byte);
               if (name_len_ff < srl_pkg::NAME_SAT) begin
                  name_len_in = name_len_ff + 4'd1;
               end
               result_in.method_byte = 1'b1;
            end else if (item.is_lparen) begin
               priority if (listen_ff && (name_len_ff == srl_pkg::LISTEN_LEN)) begin
                  result_in.call_kind = srl_pkg::CALL_LISTEN;
                  mode_in = MODE_LISTEN;
               end else if (delegate_ff && (name_len_ff == srl_pkg::DELEGATE_LEN)) begin
                  result_in.call_kind = srl_pkg::CALL_DELEGATE;
                  mode_in = MODE_DELEGATE;
               end else begin
                  result_in.call_kind = srl_pkg::CALL_OTHER;
                  mode_in = MODE_CODE;
               end
            end else begin
               mode_in = MODE_CODE;
            end
         end
         default: begin
            // error mode holds until reset
         end
      endcase

      result_in.mode = mode_in;
   end

   // Result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CODE;
         quote_dq_ff   <= 1'b0;
         str_esc_ff    <= 1'b0;
         tpl_esc_ff    <= 1'b0;
         pending_ff    <= 1'b0;
         prev_slash_ff <= 1'b0;
         prev_minus_ff <= 1'b0;
         prev_star_ff  <= 1'b0;
         name_len_ff   <= '0;
         listen_ff     <= 1'b0;
         delegate_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         result_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff       <= mode_in;
            quote_dq_ff   <= quote_dq_in;
            str_esc_ff    <= str_esc_in;
            tpl_esc_ff    <= tpl_esc_in;
            pending_ff    <= pending_in;
            prev_slash_ff <= prev_slash_in;
            prev_minus_ff <= prev_minus_in;
            prev_star_ff  <= prev_star_in;
            name_len_ff   <= name_len_in;
            listen_ff     <= listen_in;
            delegate_ff   <= delegate_in;
            result_ff     <= result_in;
         end
      end
   end

endmodule

/* rtl/script_region_lexer_fsm_core.sv */
// Script region lexer: reports the lexical mode after every byte of a script stream.
// Request channel (req_valid, req_stall, req_text_byte): one source byte per request.
// Response channel (rsp_valid, rsp_stall, rsp_*): one response per request, in order,
// with the mode after that byte, the selector text and selector close flags, the
// method name flag and the call kind at an open parenthesis.
// A request is taken at a clock edge where valid is high and stall is low.
// Stages: a taken byte passes through three stages on its way to its response (front
// decode register, two-entry queue, mode state machine with result register).
// Throughput: one byte per cycle while rsp_stall is low; the mode state machine updates on each byte it takes.
// When rsp_stall is held, the result register holds its response, the queue fills
// and then req_stall rises; no byte is lost or repeated.
// Reset (synchronous, active high) empties all stages, returns to code mode and
// clears the escape, brace, name and previous-byte tracking. The error mode entered
// after a missing second closing brace is left only through reset.
// Depends on srl_pkg, srl_front, srl_queue and srl_back.
module script_region_lexer_fsm_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_mode,
   output logic       rsp_selector_byte,
   output logic       rsp_selector_closed,
   output logic       rsp_method_byte,
   output logic [1:0] rsp_call_kind
);

   logic                push;
   srl_pkg::class_type  push_item;
   logic                queue_full;
   logic                pop;
   logic                queue_not_empty;
   srl_pkg::class_type  pop_item;
   srl_pkg::result_type result;

   // Accept and decode
   srl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_item     (push_item)
   );

   // Decoupling queue
   srl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_item  (pop_item)
   );

   // Mode state machine
   srl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result     (result)
   );

   assign rsp_mode            = result.mode;
   assign rsp_selector_byte   = result.selector_byte;
   assign rsp_selector_closed = result.selector_closed;
   assign rsp_method_byte     = result.method_byte;
   assign rsp_call_kind       = result.call_kind;

endmodule
